// ===== design/assert_macros.svh =====
// Assertion helpers for the nearest-neighbor address generator.
// Both sample on the rising edge and stay quiet while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define NNS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("nnscale assertion failed");
`define NNS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("nnscale forbidden condition seen");
`else
`define NNS_ASSERT(lbl, clk, rst_n, prop)
`define NNS_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

// ===== design/nnscale_pkg.sv =====
`default_nettype none
package nnscale_pkg;

	localparam int MAX_DIM     = 4096;
	localparam int MAX_OUT_DIM = 8192;
	localparam int FRAC_W      = 16;

	localparam int DIM_W    = 13;
	localparam int ODIM_W   = 14;
	localparam int OFS_W    = 26;
	localparam int CFG_W    = 13;
	localparam int CHAN_W   = 3;
	localparam int CNT_W    = $clog2(MAX_OUT_DIM);
	localparam int SCALE_W  = DIM_W + FRAC_W;
	localparam int DVD_W    = SCALE_W + 1;
	localparam int DIV_CNT_W = $clog2(DVD_W + 1);
	localparam int ACC_W    = FRAC_W + OFS_W;
	localparam int STRIDE_W = DIM_W + 2;

	localparam logic [CFG_W-1:0]  RST_LIMIT = 13'd1024;
	localparam logic [CHAN_W-1:0] CHAN_FOUR = 3'd4;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_PIXEL = 1'b1
	} func_t;

	typedef enum logic [2:0] {
		STAT_PIXEL     = 3'd0,
		STAT_ACCEPTED  = 3'd1,
		STAT_NO_SCALE  = 3'd2,
		STAT_TOO_LARGE = 3'd3,
		STAT_IDLE      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_FIT_MODE = 2'd0,
		CFG_LIMIT_X  = 2'd1,
		CFG_LIMIT_Y  = 2'd2,
		CFG_CHANNELS = 2'd3
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_DIV_RX,
		S_DIV_RY,
		S_SCALE,
		S_DIV_OW,
		S_DIV_OH,
		S_FINISH,
		S_ROW
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DIV_RATIO_X,
		DIV_RATIO_Y,
		DIV_OUT_W,
		DIV_OUT_H
	} div_op_t;

	typedef struct packed {
		func_t            func;
		logic [DIM_W-1:0] src_width;
		logic [DIM_W-1:0] src_height;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [ODIM_W-1:0] out_width;
		logic [ODIM_W-1:0] out_height;
		logic [OFS_W-1:0]  src_offset;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic    latch_start;
		logic    step_pixel;
		logic    div_go;
		div_op_t div_op;
		logic    div_cap;
		div_op_t cap_op;
		logic    set_scale;
		logic    commit;
		logic    row_base;
	} ctrl_cmd_t;

	typedef struct packed {
		logic no_scale;
		logic div_done;
		logic row_wrap;
	} dp_status_t;

endpackage
`default_nettype wire

// ===== design/nearest_neighbor_scale_address_gen_unit.sv =====
// Pixel item: result ready in the output queue in the cycle after acceptance; one item per
// cycle while the queue has room; the item that closes an output row adds S_ROW (row base multiply).
// Start item: four 30-step divisions in one shared divider before the result is queued, none
// when no scaling is needed. A two-entry output queue decouples the result side.
// Reset: arst_n clears control and the raster walk; fit mode, 1024 x 1024 limits, 4 channels.
`default_nettype none
module nearest_neighbor_scale_address_gen_unit (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_valid,
	output logic                             cfg_ready,
	input  wire [1:0]                        cfg_index,
	input  wire [nnscale_pkg::CFG_W-1:0]     cfg_data,
	input  wire                              req_valid,
	output logic                             req_ready,
	input  wire nnscale_pkg::req_t           req,
	output logic                             rsp_valid,
	input  wire                              rsp_ready,
	output nnscale_pkg::rsp_t                rsp
);

	nnscale_pkg::ctrl_cmd_t  cmd;
	nnscale_pkg::dp_status_t status;
	nnscale_pkg::rsp_t       item;
	logic                    push;
	logic                    q_full;

	assign cfg_ready = 1'b1;

	nnscale_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_func  (req.func),
		.req_ready (req_ready),
		.q_full    (q_full),
		.status    (status),
		.cmd       (cmd),
		.push      (push)
	);

	nnscale_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.item      (item)
	);

	nnscale_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (item),
		.full      (q_full),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire

// ===== design/nnscale_div.sv =====
`default_nettype none
module nnscale_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               go,
	input  wire [nnscale_pkg::DVD_W-1:0]      dividend,
	input  wire [nnscale_pkg::SCALE_W-1:0]    divisor,
	output logic [nnscale_pkg::DVD_W-1:0]     quotient,
	output logic                              done
);

	logic                                busy_q;
	logic                                done_q;
	logic [nnscale_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic [nnscale_pkg::SCALE_W-1:0]     rem_q;
	logic [nnscale_pkg::SCALE_W-1:0]     dvs_q;
	logic [nnscale_pkg::DVD_W-1:0]       quo_q;
	logic [nnscale_pkg::SCALE_W:0]       trial;
	logic [nnscale_pkg::SCALE_W:0]       diff;
	logic                                ge;

	// Restoring step: bring down the next dividend bit, subtract when it fits.
	assign trial = {rem_q, quo_q[nnscale_pkg::DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= nnscale_pkg::DIV_CNT_W'(nnscale_pkg::DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == nnscale_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvs_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[nnscale_pkg::SCALE_W-1:0] : trial[nnscale_pkg::SCALE_W-1:0];
			quo_q <= {quo_q[nnscale_pkg::DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule
`default_nettype wire

// ===== design/nnscale_dp.sv =====
`default_nettype none
module nnscale_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_valid,
	input  wire [1:0]                           cfg_index,
	input  wire [nnscale_pkg::CFG_W-1:0]        cfg_data,
	input  wire nnscale_pkg::req_t              req,
	input  wire nnscale_pkg::ctrl_cmd_t         cmd,
	output nnscale_pkg::dp_status_t             status,
	output nnscale_pkg::rsp_t                   item
);

	function automatic logic [nnscale_pkg::DIM_W-1:0] clamp_dim(
		input logic [nnscale_pkg::DIM_W-1:0] v
	);
		logic [nnscale_pkg::DIM_W-1:0] r;
		if (v == '0)
			r = nnscale_pkg::DIM_W'(1);
		else if (v > nnscale_pkg::DIM_W'(nnscale_pkg::MAX_DIM))
			r = nnscale_pkg::DIM_W'(nnscale_pkg::MAX_DIM);
		else
			r = v;
		return r;
	endfunction

	// configuration registers
	logic                               fit_mode_q;
	logic [nnscale_pkg::CFG_W-1:0]      limit_x_q;
	logic [nnscale_pkg::CFG_W-1:0]      limit_y_q;
	logic [nnscale_pkg::CHAN_W-1:0]     channels_q;

	// frame setup
	logic [nnscale_pkg::DIM_W-1:0]      sw_q;
	logic [nnscale_pkg::DIM_W-1:0]      sh_q;
	logic                               bpp4_q;
	logic [nnscale_pkg::SCALE_W-1:0]    scale_q;
	logic [nnscale_pkg::SCALE_W-1:0]    ratio_y_q;
	logic [nnscale_pkg::ODIM_W-1:0]     res_w_q;
	logic [nnscale_pkg::ODIM_W-1:0]     res_h_q;
	logic                               big_q;
	logic [nnscale_pkg::STRIDE_W-1:0]   stride_q;

	// raster walk
	logic                               active_q;
	logic [nnscale_pkg::CNT_W-1:0]      col_q;
	logic [nnscale_pkg::CNT_W-1:0]      row_q;
	logic [nnscale_pkg::ACC_W-1:0]      col_acc_q;
	logic [nnscale_pkg::ACC_W-1:0]      row_acc_q;
	logic [nnscale_pkg::OFS_W-1:0]      row_base_q;

	logic [nnscale_pkg::DIM_W-1:0]      lim_x;
	logic [nnscale_pkg::DIM_W-1:0]      lim_y;
	logic                               no_scale;
	logic [nnscale_pkg::SCALE_W-1:0]    s_sel;
	logic [nnscale_pkg::DIM_W-1:0]      dim_sel;
	logic [nnscale_pkg::DVD_W-1:0]      div_dvd;
	logic [nnscale_pkg::SCALE_W-1:0]    div_dvs;
	logic [nnscale_pkg::DVD_W-1:0]      div_quo;
	logic                               div_done;
	logic                               quo_big;

	logic [nnscale_pkg::ODIM_W-1:0]     col_next;
	logic [nnscale_pkg::ODIM_W-1:0]     row_next;
	logic                               col_last;
	logic                               fin;
	logic [nnscale_pkg::OFS_W-1:0]      sx;
	logic [nnscale_pkg::OFS_W-1:0]      sx_bytes;
	logic [nnscale_pkg::OFS_W-1:0]      sy;
	logic [nnscale_pkg::OFS_W+nnscale_pkg::STRIDE_W-1:0] row_prod;
	logic                               accept_frame;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q <= 1'b1;
			limit_x_q  <= nnscale_pkg::RST_LIMIT;
			limit_y_q  <= nnscale_pkg::RST_LIMIT;
			channels_q <= nnscale_pkg::CHAN_FOUR;
		end else if (cfg_valid) begin
			unique case (nnscale_pkg::cfg_reg_t'(cfg_index))
				nnscale_pkg::CFG_FIT_MODE: fit_mode_q <= cfg_data[0];
				nnscale_pkg::CFG_LIMIT_X:  limit_x_q  <= cfg_data;
				nnscale_pkg::CFG_LIMIT_Y:  limit_y_q  <= cfg_data;
				nnscale_pkg::CFG_CHANNELS: channels_q <= cfg_data[nnscale_pkg::CHAN_W-1:0];
			endcase
		end
	end

	assign lim_x = clamp_dim(limit_x_q);
	assign lim_y = clamp_dim(limit_y_q);

	assign no_scale = fit_mode_q ? (lim_x > sw_q && lim_y > sh_q)
	                             : (lim_x < sw_q && lim_y < sh_q);

	// Fit takes the larger ratio, cover the smaller; stays equal to scale_q once set.
	assign s_sel = fit_mode_q ? ((scale_q > ratio_y_q) ? scale_q : ratio_y_q)
	                          : ((scale_q < ratio_y_q) ? scale_q : ratio_y_q);

	always_comb begin
		dim_sel = sw_q;
		div_dvd = '0;
		div_dvs = '0;
		unique case (cmd.div_op)
			nnscale_pkg::DIV_RATIO_X: begin
				div_dvd = nnscale_pkg::DVD_W'({sw_q, {nnscale_pkg::FRAC_W{1'b0}}});
				div_dvs = nnscale_pkg::SCALE_W'(lim_x);
			end
			nnscale_pkg::DIV_RATIO_Y: begin
				div_dvd = nnscale_pkg::DVD_W'({sh_q, {nnscale_pkg::FRAC_W{1'b0}}});
				div_dvs = nnscale_pkg::SCALE_W'(lim_y);
			end
			nnscale_pkg::DIV_OUT_W, nnscale_pkg::DIV_OUT_H: begin
				dim_sel = (cmd.div_op == nnscale_pkg::DIV_OUT_W) ? sw_q : sh_q;
				// round up in cover mode
				div_dvd = nnscale_pkg::DVD_W'({dim_sel, {nnscale_pkg::FRAC_W{1'b0}}})
				        + (fit_mode_q ? '0
				                      : nnscale_pkg::DVD_W'(s_sel) - nnscale_pkg::DVD_W'(1));
				div_dvs = s_sel;
			end
		endcase
	end

	nnscale_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.done     (div_done)
	);

	assign quo_big = div_quo > nnscale_pkg::DVD_W'(nnscale_pkg::MAX_OUT_DIM);

	// pixel address
	assign col_next = {1'b0, col_q} + nnscale_pkg::ODIM_W'(1);
	assign row_next = {1'b0, row_q} + nnscale_pkg::ODIM_W'(1);
	assign col_last = col_next == res_w_q;
	assign fin      = col_last && (row_next == res_h_q);
	assign sx       = col_acc_q[nnscale_pkg::FRAC_W +: nnscale_pkg::OFS_W];
	assign sx_bytes = bpp4_q ? {sx[nnscale_pkg::OFS_W-3:0], 2'b00}
	                         : sx + {sx[nnscale_pkg::OFS_W-2:0], 1'b0};
	assign sy       = row_acc_q[nnscale_pkg::FRAC_W +: nnscale_pkg::OFS_W];
	assign row_prod = nnscale_pkg::OFS_W'(sy) * nnscale_pkg::STRIDE_W'(stride_q)
	                  + {(nnscale_pkg::OFS_W+nnscale_pkg::STRIDE_W){1'b0}};

	assign accept_frame = !no_scale && !big_q;

	always_ff @(posedge clk) begin
		if (cmd.latch_start) begin
			sw_q   <= clamp_dim(req.src_width);
			sh_q   <= clamp_dim(req.src_height);
			bpp4_q <= channels_q == nnscale_pkg::CHAN_FOUR;
		end
		if (cmd.div_cap) begin
			unique case (cmd.cap_op)
				nnscale_pkg::DIV_RATIO_X: scale_q   <= div_quo[nnscale_pkg::SCALE_W-1:0];
				nnscale_pkg::DIV_RATIO_Y: ratio_y_q <= div_quo[nnscale_pkg::SCALE_W-1:0];
				nnscale_pkg::DIV_OUT_W:   res_w_q   <= div_quo[nnscale_pkg::ODIM_W-1:0];
				nnscale_pkg::DIV_OUT_H:   res_h_q   <= div_quo[nnscale_pkg::ODIM_W-1:0];
			endcase
		end
		if (cmd.set_scale)
			scale_q <= s_sel;
		if (cmd.commit)
			stride_q <= bpp4_q ? {sw_q, 2'b00}
			                   : nnscale_pkg::STRIDE_W'({sw_q, 1'b0})
			                     + nnscale_pkg::STRIDE_W'(sw_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			big_q      <= 1'b0;
			active_q   <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			col_acc_q  <= '0;
			row_acc_q  <= '0;
			row_base_q <= '0;
		end else begin
			if (cmd.latch_start)
				big_q <= 1'b0;
			else if (cmd.div_cap && (cmd.cap_op == nnscale_pkg::DIV_OUT_W
			                         || cmd.cap_op == nnscale_pkg::DIV_OUT_H))
				big_q <= big_q | quo_big;

			if (cmd.commit) begin
				active_q   <= accept_frame && res_w_q != '0 && res_h_q != '0;
				col_q      <= '0;
				row_q      <= '0;
				col_acc_q  <= '0;
				row_acc_q  <= '0;
				row_base_q <= '0;
			end else if (cmd.step_pixel && active_q) begin
				if (fin) begin
					active_q <= 1'b0;
				end else if (col_last) begin
					col_q     <= '0;
					col_acc_q <= '0;
					row_q     <= row_q + 1'b1;
					row_acc_q <= row_acc_q + nnscale_pkg::ACC_W'(scale_q);
				end else begin
					col_q     <= col_q + 1'b1;
					col_acc_q <= col_acc_q + nnscale_pkg::ACC_W'(scale_q);
				end
			end else if (cmd.row_base) begin
				row_base_q <= row_prod[nnscale_pkg::OFS_W-1:0];
			end
		end
	end

	always_comb begin
		item = '0;
		if (cmd.commit) begin
			if (no_scale) begin
				item.status = nnscale_pkg::STAT_NO_SCALE;
			end else if (big_q) begin
				item.status = nnscale_pkg::STAT_TOO_LARGE;
			end else begin
				item.status     = nnscale_pkg::STAT_ACCEPTED;
				item.out_width  = res_w_q;
				item.out_height = res_h_q;
			end
		end else if (active_q) begin
			item.status     = nnscale_pkg::STAT_PIXEL;
			item.out_width  = res_w_q;
			item.out_height = res_h_q;
			item.src_offset = row_base_q + sx_bytes;
			item.last       = fin;
		end else begin
			item.status = nnscale_pkg::STAT_IDLE;
		end
	end

	assign status.no_scale = no_scale;
	assign status.div_done = div_done;
	assign status.row_wrap = active_q && col_last && !fin;

endmodule
`default_nettype wire

// ===== design/nnscale_outq.sv =====
`default_nettype none
module nnscale_outq (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     push,
	input  wire nnscale_pkg::rsp_t  push_item,
	output logic                    full,
	output logic                    rsp_valid,
	input  wire                     rsp_ready,
	output nnscale_pkg::rsp_t       rsp
);

	nnscale_pkg::rsp_t ent_q [2];
	logic [1:0]        cnt_q;
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic              pop;

	assign pop       = rsp_valid && rsp_ready;
	assign full      = cnt_q == 2'd2;
	assign rsp_valid = cnt_q != 2'd0;
	assign rsp       = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
		end
	end

endmodule
`default_nettype wire

// ===== design/nnscale_ctrl.sv =====
`default_nettype none
`include "assert_macros.svh"
module nnscale_ctrl (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	input  wire nnscale_pkg::func_t          req_func,
	output logic                             req_ready,
	input  wire                              q_full,
	input  wire nnscale_pkg::dp_status_t     status,
	output nnscale_pkg::ctrl_cmd_t           cmd,
	output logic                             push
);

	nnscale_pkg::ctrl_state_t state_q;
	nnscale_pkg::ctrl_state_t state_d;
	logic                     accept;

	assign req_ready = (state_q == nnscale_pkg::S_IDLE) && !q_full;
	assign accept    = req_valid && req_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= nnscale_pkg::S_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nnscale_pkg::S_IDLE: begin
				if (accept) begin
					if (req_func == nnscale_pkg::FUNC_START)
						state_d = nnscale_pkg::S_CHECK;
					else if (status.row_wrap)
						state_d = nnscale_pkg::S_ROW;
				end
			end
			nnscale_pkg::S_CHECK: begin
				state_d = status.no_scale ? nnscale_pkg::S_FINISH : nnscale_pkg::S_DIV_RX;
			end
			nnscale_pkg::S_DIV_RX: begin
				if (status.div_done)
					state_d = nnscale_pkg::S_DIV_RY;
			end
			nnscale_pkg::S_DIV_RY: begin
				if (status.div_done)
					state_d = nnscale_pkg::S_SCALE;
			end
			nnscale_pkg::S_SCALE: begin
				state_d = nnscale_pkg::S_DIV_OW;
			end
			nnscale_pkg::S_DIV_OW: begin
				if (status.div_done)
					state_d = nnscale_pkg::S_DIV_OH;
			end
			nnscale_pkg::S_DIV_OH: begin
				if (status.div_done)
					state_d = nnscale_pkg::S_FINISH;
			end
			nnscale_pkg::S_FINISH: begin
				if (!q_full)
					state_d = nnscale_pkg::S_IDLE;
			end
			nnscale_pkg::S_ROW: begin
				state_d = nnscale_pkg::S_IDLE;
			end
			default: state_d = nnscale_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.div_op = nnscale_pkg::DIV_RATIO_X;
		cmd.cap_op = nnscale_pkg::DIV_RATIO_X;
		push       = 1'b0;
		unique case (state_q)
			nnscale_pkg::S_IDLE: begin
				cmd.latch_start = accept && (req_func == nnscale_pkg::FUNC_START);
				cmd.step_pixel  = accept && (req_func == nnscale_pkg::FUNC_PIXEL);
				push            = cmd.step_pixel;
			end
			nnscale_pkg::S_CHECK: begin
				cmd.div_go = !status.no_scale;
				cmd.div_op = nnscale_pkg::DIV_RATIO_X;
			end
			nnscale_pkg::S_DIV_RX: begin
				cmd.div_cap = status.div_done;
				cmd.cap_op  = nnscale_pkg::DIV_RATIO_X;
				cmd.div_go  = status.div_done;
				cmd.div_op  = nnscale_pkg::DIV_RATIO_Y;
			end
			nnscale_pkg::S_DIV_RY: begin
				cmd.div_cap = status.div_done;
				cmd.cap_op  = nnscale_pkg::DIV_RATIO_Y;
			end
			nnscale_pkg::S_SCALE: begin
				cmd.set_scale = 1'b1;
				cmd.div_go    = 1'b1;
				cmd.div_op    = nnscale_pkg::DIV_OUT_W;
			end
			nnscale_pkg::S_DIV_OW: begin
				cmd.div_cap = status.div_done;
				cmd.cap_op  = nnscale_pkg::DIV_OUT_W;
				cmd.div_go  = status.div_done;
				cmd.div_op  = nnscale_pkg::DIV_OUT_H;
			end
			nnscale_pkg::S_DIV_OH: begin
				cmd.div_cap = status.div_done;
				cmd.cap_op  = nnscale_pkg::DIV_OUT_H;
			end
			nnscale_pkg::S_FINISH: begin
				// hold the frame result until the output queue has room
				cmd.commit = !q_full;
				push       = !q_full;
			end
			nnscale_pkg::S_ROW: begin
				cmd.row_base = 1'b1;
			end
			default: begin
			end
		endcase
	end

	`NNS_NEVER(a_push_when_full, clk, arst_n, push && q_full)
	`NNS_NEVER(a_div_done_outside_wait, clk, arst_n, status.div_done && !(state_q == nnscale_pkg::S_DIV_RX || state_q == nnscale_pkg::S_DIV_RY || state_q == nnscale_pkg::S_DIV_OW || state_q == nnscale_pkg::S_DIV_OH))
	`NNS_ASSERT(a_wrap_loads_row, clk, arst_n, (cmd.step_pixel && status.row_wrap) |=> (state_q == nnscale_pkg::S_ROW))

endmodule
`default_nettype wire
